@@ design/iirdf1_pkg.sv @@
// ---------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants for the direct-form I IIR filter.
// ---------------------------------------------------------------------------
package iirdf1_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 18;
  localparam int MUL_A_W    = 20;                  // multiplier sample-side operand
  localparam int PROD_W     = MUL_A_W + COEFF_W;
  localparam int ACC_W      = 37;                  // five Q.29 products
  localparam int SPLIT      = 19;                  // low slice of acc for scaling
  localparam int SCL_W      = 55;                  // acc * a0_recip
  localparam int RND_SHIFT  = 28;
  localparam int YQ_W       = SCL_W - RND_SHIFT;
  localparam int TAP_IDX_W  = 2;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic signed [SCL_W-1:0] RND_HALF = SCL_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [YQ_W-1:0]  SAT_HI   = YQ_W'(32'sd32767);
  localparam logic signed [YQ_W-1:0]  SAT_LO   = YQ_W'(-32'sd32768);

  localparam logic [REG_IDX_W-1:0] REG_B0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A2  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A0R = 3'd5;

  localparam logic signed [COEFF_W-1:0] B0_RESET  = 18'sd16384;
  localparam logic signed [COEFF_W-1:0] A0R_RESET = 18'sd16384;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_BU   = 3'd1,   // b0 * new sample, starts the sum
    OP_BX   = 3'd2,   // b_i * past input, added
    OP_AY   = 3'd3,   // a_i * past output, subtracted
    OP_SLO  = 3'd4,   // low slice of sum * a0_recip
    OP_SHI  = 3'd5    // high slice of sum * a0_recip
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [TAP_IDX_W-1:0] idx;
    logic                 load;
    logic                 commit;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] b0;
    logic signed [COEFF_W-1:0] b1;
    logic signed [COEFF_W-1:0] b2;
    logic signed [COEFF_W-1:0] a1;
    logic signed [COEFF_W-1:0] a2;
    logic signed [COEFF_W-1:0] a0r;
  } coeffs_t;

endpackage

@@ design/iirdf1_regs.sv @@
// ---------------------------------------------------------------------------
// iirdf1_regs
// APB coefficient registers; writes outside the register list are dropped.
// ---------------------------------------------------------------------------
module iirdf1_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iirdf1_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [iirdf1_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [iirdf1_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  output iirdf1_pkg::coeffs_t                 coeffs
);

  iirdf1_pkg::coeffs_t coeffs_r, coeffs_nxt;
  logic [iirdf1_pkg::REG_IDX_W-1:0] idx;
  logic signed [iirdf1_pkg::COEFF_W-1:0] wval;
  logic signed [iirdf1_pkg::COEFF_W-1:0] rval;
  logic wr_en;

  assign idx    = paddr[iirdf1_pkg::APB_ADDR_W-1:2];
  assign wval   = $signed(pwdata[iirdf1_pkg::COEFF_W-1:0]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    coeffs_nxt = coeffs_r;
    if (wr_en) begin
      case (idx)
        iirdf1_pkg::REG_B0:  coeffs_nxt.b0  = wval;
        iirdf1_pkg::REG_B1:  coeffs_nxt.b1  = wval;
        iirdf1_pkg::REG_B2:  coeffs_nxt.b2  = wval;
        iirdf1_pkg::REG_A1:  coeffs_nxt.a1  = wval;
        iirdf1_pkg::REG_A2:  coeffs_nxt.a2  = wval;
        iirdf1_pkg::REG_A0R: coeffs_nxt.a0r = wval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeffs_r.b0  <= iirdf1_pkg::B0_RESET;
      coeffs_r.b1  <= '0;
      coeffs_r.b2  <= '0;
      coeffs_r.a1  <= '0;
      coeffs_r.a2  <= '0;
      coeffs_r.a0r <= iirdf1_pkg::A0R_RESET;
    end else begin
      coeffs_r <= coeffs_nxt;
    end
  end

  always_comb begin
    case (idx)
      iirdf1_pkg::REG_B0:  rval = coeffs_r.b0;
      iirdf1_pkg::REG_B1:  rval = coeffs_r.b1;
      iirdf1_pkg::REG_B2:  rval = coeffs_r.b2;
      iirdf1_pkg::REG_A1:  rval = coeffs_r.a1;
      iirdf1_pkg::REG_A2:  rval = coeffs_r.a2;
      iirdf1_pkg::REG_A0R: rval = coeffs_r.a0r;
      default:             rval = '0;
    endcase
  end

  assign prdata = iirdf1_pkg::APB_DATA_W'(rval);
  assign coeffs = coeffs_r;

endmodule

@@ design/iirdf1_dp.sv @@
// ---------------------------------------------------------------------------
// iirdf1_dp
// Datapath: shared registered multiplier, accumulator, scaling, rounding,
// saturation, sample histories and the output register.
// ---------------------------------------------------------------------------
module iirdf1_dp #(
  parameter int FILTER_ORDER = 2
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  iirdf1_pkg::dp_cmd_t                     cmd,
  input  iirdf1_pkg::coeffs_t                     coeffs,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                    out_clipped
);

  localparam int H2 = (FILTER_ORDER >= 2) ? 1 : 0;

  logic signed [iirdf1_pkg::SAMPLE_W-1:0] u_r;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_r [FILTER_ORDER];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_r [FILTER_ORDER];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] hx, hy;

  logic signed [iirdf1_pkg::MUL_A_W-1:0] ma;
  logic signed [iirdf1_pkg::COEFF_W-1:0] mb;
  logic signed [iirdf1_pkg::PROD_W-1:0]  prod_r;
  iirdf1_pkg::op_t                       op_d_r;

  logic signed [iirdf1_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [iirdf1_pkg::SCL_W-1:0] sc_r, sc_nxt;
  logic signed [iirdf1_pkg::SCL_W-1:0] rnd;
  logic signed [iirdf1_pkg::YQ_W-1:0]  yq;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] ysat;
  logic                                   clip;

  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_out_r;
  logic                                   clipped_r;

  assign hx = (cmd.idx == 2'd1) ? x_r[0] : x_r[H2];
  assign hy = (cmd.idx == 2'd1) ? y_r[0] : y_r[H2];

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      iirdf1_pkg::OP_BU: begin
        ma = iirdf1_pkg::MUL_A_W'(u_r);
        mb = coeffs.b0;
      end
      iirdf1_pkg::OP_BX: begin
        ma = iirdf1_pkg::MUL_A_W'(hx);
        mb = (cmd.idx == 2'd1) ? coeffs.b1 : coeffs.b2;
      end
      iirdf1_pkg::OP_AY: begin
        ma = iirdf1_pkg::MUL_A_W'(hy);
        mb = (cmd.idx == 2'd1) ? coeffs.a1 : coeffs.a2;
      end
      iirdf1_pkg::OP_SLO: begin
        ma = $signed({1'b0, acc_r[iirdf1_pkg::SPLIT-1:0]});
        mb = coeffs.a0r;
      end
      iirdf1_pkg::OP_SHI: begin
        ma = iirdf1_pkg::MUL_A_W'($signed(acc_r[iirdf1_pkg::ACC_W-1:iirdf1_pkg::SPLIT]));
        mb = coeffs.a0r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_d_r <= iirdf1_pkg::OP_NONE;
    end else begin
      op_d_r <= cmd.op;
    end
  end

  // products are registered and land in the cycle after issue
  always_comb begin
    acc_nxt = acc_r;
    sc_nxt  = sc_r;
    case (op_d_r)
      iirdf1_pkg::OP_BU:  acc_nxt = iirdf1_pkg::ACC_W'(prod_r);
      iirdf1_pkg::OP_BX:  acc_nxt = acc_r + iirdf1_pkg::ACC_W'(prod_r);
      iirdf1_pkg::OP_AY:  acc_nxt = acc_r - iirdf1_pkg::ACC_W'(prod_r);
      iirdf1_pkg::OP_SLO: sc_nxt  = iirdf1_pkg::SCL_W'(prod_r);
      iirdf1_pkg::OP_SHI: sc_nxt  = sc_r + (iirdf1_pkg::SCL_W'(prod_r) <<< iirdf1_pkg::SPLIT);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sc_r  <= sc_nxt;
  end

  // round half up, then clamp to Q1.15
  assign rnd = sc_r + iirdf1_pkg::RND_HALF;
  assign yq  = $signed(rnd[iirdf1_pkg::SCL_W-1:iirdf1_pkg::RND_SHIFT]);

  always_comb begin
    if (yq > iirdf1_pkg::SAT_HI) begin
      ysat = iirdf1_pkg::SAMPLE_W'(iirdf1_pkg::SAT_HI);
      clip = 1'b1;
    end else if (yq < iirdf1_pkg::SAT_LO) begin
      ysat = iirdf1_pkg::SAMPLE_W'(iirdf1_pkg::SAT_LO);
      clip = 1'b1;
    end else begin
      ysat = iirdf1_pkg::SAMPLE_W'(yq);
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r <= in_sample_in;
    end
    if (cmd.commit) begin
      sample_out_r <= ysat;
      clipped_r    <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_ORDER; i++) begin
        x_r[i] <= '0;
        y_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      x_r[0] <= u_r;
      y_r[0] <= ysat;
      for (int i = 1; i < FILTER_ORDER; i++) begin
        x_r[i] <= x_r[i-1];
        y_r[i] <= y_r[i-1];
      end
    end
  end

  assign out_sample_out = sample_out_r;
  assign out_clipped    = clipped_r;

endmodule

@@ design/iirdf1_ctrl.sv @@
// ---------------------------------------------------------------------------
// iirdf1_ctrl
// Sequencer: steps the datapath through the taps and the scaling, and owns
// the channel handshakes.
// ---------------------------------------------------------------------------
module iirdf1_ctrl #(
  parameter int FILTER_ORDER = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iirdf1_pkg::dp_cmd_t  cmd
);

  // taps beyond the second carry no coefficient and are skipped
  localparam int NB    = (FILTER_ORDER < 2) ? FILTER_ORDER : 2;
  localparam int NTAPS = 1 + 2 * NB;
  localparam int CNT_W = $clog2(NTAPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NTAPS - 1);
  localparam logic [CNT_W-1:0] NB_C = CNT_W'(NB);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TAP    = 7'b0000010,
    S_WAIT   = 7'b0000100,
    S_SCL_LO = 7'b0001000,
    S_SCL_HI = 7'b0010000,
    S_ADD_HI = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             commit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign commit   = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = iirdf1_pkg::OP_NONE;
    cmd.idx   = '0;
    cmd.load  = accept;
    cmd.commit = commit;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_TAP;
          cnt_nxt   = '0;
        end
      end
      S_TAP: begin
        if (cnt_r == '0) begin
          cmd.op = iirdf1_pkg::OP_BU;
        end else if (cnt_r <= NB_C) begin
          cmd.op  = iirdf1_pkg::OP_BX;
          cmd.idx = iirdf1_pkg::TAP_IDX_W'(cnt_r);
        end else begin
          cmd.op  = iirdf1_pkg::OP_AY;
          cmd.idx = iirdf1_pkg::TAP_IDX_W'(cnt_r - NB_C);
        end
        if (cnt_r == LAST) begin
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_WAIT:   state_nxt = S_SCL_LO;   // last tap lands in the sum
      S_SCL_LO: begin
        cmd.op    = iirdf1_pkg::OP_SLO;
        state_nxt = S_SCL_HI;
      end
      S_SCL_HI: begin
        cmd.op    = iirdf1_pkg::OP_SHI;
        state_nxt = S_ADD_HI;
      end
      S_ADD_HI: state_nxt = S_FINISH;
      S_FINISH: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r != S_FINISH) |=> out_valid_r)
    else $error("pending result dropped");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("committed result not presented");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_TAP && cnt_r == '0))
    else $error("accepted item did not start the tap sequence");

  a_finish_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=> state_r == S_FINISH)
    else $error("result overwritten while receiver stalls");
`endif

endmodule

@@ design/iir_direct_form_one_filter.sv @@
// ---------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct-form I IIR filter, Q1.15 samples, Q4.14 coefficients.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one Q1.15 sample per item; the
//   result channel out_valid/out_ready returns the filtered, saturated sample
//   and a clip flag, one result per item, in order.
//   Coefficients b0..b2, a1, a2 and the reciprocal of a0 sit on the APB port
//   at byte addresses 0x00..0x14; write them only while the filter is idle.
//   One multiplier is shared by all taps and by the two-slice scaling of the
//   sum, so a new item is accepted only in the idle state, once the taps,
//   the scaling and the commit of the previous item are done.
//   The result shows on out_valid when it is committed, after the taps, the
//   two scaling slices and the rounding and saturation of the sum.
//   Reset (rst_n low, synchronous) clears both sample histories, loads the
//   coefficient reset values and empties the output register.
//   The output register holds one result; a new item is taken while it waits,
//   but the next result is held back until the receiver takes the old one.
// ---------------------------------------------------------------------------
module iir_direct_form_one_filter #(
  parameter int FILTER_ORDER = 2
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                    out_clipped,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [iirdf1_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [iirdf1_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [iirdf1_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                    pready
);

  iirdf1_pkg::coeffs_t coeffs;
  iirdf1_pkg::dp_cmd_t cmd;

  iirdf1_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeffs  (coeffs)
  );

  iirdf1_ctrl #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  iirdf1_dp #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .coeffs         (coeffs),
    .in_sample_in   (in_sample_in),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

endmodule
